// File: rtl/rvcls_pkg.sv
// ----------------------------------------------------------------------------
// rvcls_pkg
// Shared types and encodings for the RV32E / RVC instruction classifier.
// ----------------------------------------------------------------------------
package rvcls_pkg;

    // Format classes
    localparam logic [4:0] FMT_R    = 5'd0;
    localparam logic [4:0] FMT_I    = 5'd1;
    localparam logic [4:0] FMT_S    = 5'd2;
    localparam logic [4:0] FMT_B    = 5'd3;
    localparam logic [4:0] FMT_U    = 5'd4;
    localparam logic [4:0] FMT_J    = 5'd5;
    localparam logic [4:0] FMT_MISC = 5'd6;
    localparam logic [4:0] FMT_CR   = 5'd7;
    localparam logic [4:0] FMT_CI   = 5'd8;
    localparam logic [4:0] FMT_CSS  = 5'd9;
    localparam logic [4:0] FMT_CIW  = 5'd10;
    localparam logic [4:0] FMT_CL   = 5'd11;
    localparam logic [4:0] FMT_CS   = 5'd12;
    localparam logic [4:0] FMT_CA   = 5'd13;
    localparam logic [4:0] FMT_CB   = 5'd14;
    localparam logic [4:0] FMT_CJ   = 5'd15;
    localparam logic [4:0] FMT_BAD  = 5'd16;

    // Base instruction ids
    localparam logic [6:0] I_ADD    = 7'd0;
    localparam logic [6:0] I_SUB    = 7'd1;
    localparam logic [6:0] I_SLL    = 7'd2;
    localparam logic [6:0] I_SLT    = 7'd3;
    localparam logic [6:0] I_SLTU   = 7'd4;
    localparam logic [6:0] I_XOR    = 7'd5;
    localparam logic [6:0] I_SRL    = 7'd6;
    localparam logic [6:0] I_SRA    = 7'd7;
    localparam logic [6:0] I_OR     = 7'd8;
    localparam logic [6:0] I_AND    = 7'd9;
    localparam logic [6:0] I_ADDI   = 7'd10;
    localparam logic [6:0] I_SLLI   = 7'd11;
    localparam logic [6:0] I_SLTI   = 7'd12;
    localparam logic [6:0] I_SLTIU  = 7'd13;
    localparam logic [6:0] I_XORI   = 7'd14;
    localparam logic [6:0] I_SRLI   = 7'd15;
    localparam logic [6:0] I_SRAI   = 7'd16;
    localparam logic [6:0] I_ORI    = 7'd17;
    localparam logic [6:0] I_ANDI   = 7'd18;
    localparam logic [6:0] I_BEQ    = 7'd19;
    localparam logic [6:0] I_BNE    = 7'd20;
    localparam logic [6:0] I_BLT    = 7'd21;
    localparam logic [6:0] I_BGE    = 7'd22;
    localparam logic [6:0] I_BLTU   = 7'd23;
    localparam logic [6:0] I_BGEU   = 7'd24;
    localparam logic [6:0] I_LUI    = 7'd25;
    localparam logic [6:0] I_AUIPC  = 7'd26;
    localparam logic [6:0] I_JAL    = 7'd27;
    localparam logic [6:0] I_JALR   = 7'd28;
    localparam logic [6:0] I_LB     = 7'd29;
    localparam logic [6:0] I_LH     = 7'd30;
    localparam logic [6:0] I_LW     = 7'd31;
    localparam logic [6:0] I_LBU    = 7'd32;
    localparam logic [6:0] I_LHU    = 7'd33;
    localparam logic [6:0] I_SB     = 7'd34;
    localparam logic [6:0] I_SH     = 7'd35;
    localparam logic [6:0] I_SW     = 7'd36;
    localparam logic [6:0] I_FENCE  = 7'd37;
    localparam logic [6:0] I_EBREAK = 7'd38;
    localparam logic [6:0] I_ECALL  = 7'd39;

    // Compressed instruction ids
    localparam logic [6:0] K_ADDI4SPN = 7'd40;
    localparam logic [6:0] K_LW       = 7'd41;
    localparam logic [6:0] K_FSD      = 7'd42;
    localparam logic [6:0] K_SW       = 7'd43;
    localparam logic [6:0] K_NOP      = 7'd44;
    localparam logic [6:0] K_ADDI     = 7'd45;
    localparam logic [6:0] K_JAL      = 7'd46;
    localparam logic [6:0] K_LI       = 7'd47;
    localparam logic [6:0] K_ADDI16SP = 7'd48;
    localparam logic [6:0] K_LUI      = 7'd49;
    localparam logic [6:0] K_SRLI     = 7'd50;
    localparam logic [6:0] K_SRAI     = 7'd51;
    localparam logic [6:0] K_ANDI     = 7'd52;
    localparam logic [6:0] K_SUB      = 7'd53;
    localparam logic [6:0] K_XOR      = 7'd54;
    localparam logic [6:0] K_OR       = 7'd55;
    localparam logic [6:0] K_AND      = 7'd56;
    localparam logic [6:0] K_J        = 7'd57;
    localparam logic [6:0] K_BEQZ     = 7'd58;
    localparam logic [6:0] K_BNEZ     = 7'd59;
    localparam logic [6:0] K_SLLI     = 7'd60;
    localparam logic [6:0] K_LWSP     = 7'd61;
    localparam logic [6:0] K_JR       = 7'd62;
    localparam logic [6:0] K_MV       = 7'd63;
    localparam logic [6:0] K_EBREAK   = 7'd64;
    localparam logic [6:0] K_JALR     = 7'd65;
    localparam logic [6:0] K_ADD      = 7'd66;
    localparam logic [6:0] K_SWSP     = 7'd67;

    // Base opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Quadrant codes
    localparam logic [1:0] QUAD_0    = 2'b00;
    localparam logic [1:0] QUAD_1    = 2'b01;
    localparam logic [1:0] QUAD_2    = 2'b10;
    localparam logic [1:0] QUAD_BASE = 2'b11;

    // Decoder result
    typedef struct packed {
        logic       ok;
        logic [4:0] fmt;
        logic [6:0] id;
    } dec_res_t;

endpackage

// File: rtl/rvcls_base_dec.sv
// ----------------------------------------------------------------------------
// rvcls_base_dec
// Combinational decoder for 32-bit RV32E instructions.
// ----------------------------------------------------------------------------
module rvcls_base_dec (
    input  logic [31:0]              instr,
    output rvcls_pkg::dec_res_t      res
);

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;

    assign opc = instr[6:0];
    assign f3  = instr[14:12];
    assign f7  = instr[31:25];

    always_comb begin
        res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_BAD, id: 7'd0};
        case (opc)
            rvcls_pkg::OPC_OP: begin
                res.fmt = rvcls_pkg::FMT_R;
                case (f3)
                    3'd0, 3'd5: begin
                        // shift/add pairs need an exact funct7
                        if (f7 == rvcls_pkg::F7_BASE) begin
                            res.id = (f3 == 3'd0) ? rvcls_pkg::I_ADD : rvcls_pkg::I_SRL;
                        end else if (f7 == rvcls_pkg::F7_ALT) begin
                            res.id = (f3 == 3'd0) ? rvcls_pkg::I_SUB : rvcls_pkg::I_SRA;
                        end else begin
                            res.ok = 1'b0;
                        end
                    end
                    3'd1:    res.id = rvcls_pkg::I_SLL;
                    3'd2:    res.id = rvcls_pkg::I_SLT;
                    3'd3:    res.id = rvcls_pkg::I_SLTU;
                    3'd4:    res.id = rvcls_pkg::I_XOR;
                    3'd6:    res.id = rvcls_pkg::I_OR;
                    default: res.id = rvcls_pkg::I_AND;
                endcase
            end
            rvcls_pkg::OPC_OP_IMM: begin
                res.fmt = rvcls_pkg::FMT_I;
                case (f3)
                    3'd0: res.id = rvcls_pkg::I_ADDI;
                    3'd1: res.id = rvcls_pkg::I_SLLI;
                    3'd2: res.id = rvcls_pkg::I_SLTI;
                    3'd3: res.id = rvcls_pkg::I_SLTIU;
                    3'd4: res.id = rvcls_pkg::I_XORI;
                    3'd5: begin
                        if (f7 == rvcls_pkg::F7_BASE) begin
                            res.id = rvcls_pkg::I_SRLI;
                        end else if (f7 == rvcls_pkg::F7_ALT) begin
                            res.id = rvcls_pkg::I_SRAI;
                        end else begin
                            res.ok = 1'b0;
                        end
                    end
                    3'd6:    res.id = rvcls_pkg::I_ORI;
                    default: res.id = rvcls_pkg::I_ANDI;
                endcase
            end
            rvcls_pkg::OPC_BRANCH: begin
                res.fmt = rvcls_pkg::FMT_B;
                case (f3)
                    3'd0:    res.id = rvcls_pkg::I_BEQ;
                    3'd1:    res.id = rvcls_pkg::I_BNE;
                    3'd4:    res.id = rvcls_pkg::I_BLT;
                    3'd5:    res.id = rvcls_pkg::I_BGE;
                    3'd6:    res.id = rvcls_pkg::I_BLTU;
                    3'd7:    res.id = rvcls_pkg::I_BGEU;
                    default: res.ok = 1'b0;
                endcase
            end
            rvcls_pkg::OPC_LUI: begin
                res.fmt = rvcls_pkg::FMT_U;
                res.id  = rvcls_pkg::I_LUI;
            end
            rvcls_pkg::OPC_AUIPC: begin
                res.fmt = rvcls_pkg::FMT_U;
                res.id  = rvcls_pkg::I_AUIPC;
            end
            rvcls_pkg::OPC_JAL: begin
                res.fmt = rvcls_pkg::FMT_J;
                res.id  = rvcls_pkg::I_JAL;
            end
            rvcls_pkg::OPC_JALR: begin
                res.fmt = rvcls_pkg::FMT_I;
                res.id  = rvcls_pkg::I_JALR;
            end
            rvcls_pkg::OPC_LOAD: begin
                res.fmt = rvcls_pkg::FMT_I;
                case (f3)
                    3'd0:    res.id = rvcls_pkg::I_LB;
                    3'd1:    res.id = rvcls_pkg::I_LH;
                    3'd2:    res.id = rvcls_pkg::I_LW;
                    3'd4:    res.id = rvcls_pkg::I_LBU;
                    3'd5:    res.id = rvcls_pkg::I_LHU;
                    default: res.ok = 1'b0;
                endcase
            end
            rvcls_pkg::OPC_STORE: begin
                res.fmt = rvcls_pkg::FMT_S;
                case (f3)
                    3'd0:    res.id = rvcls_pkg::I_SB;
                    3'd1:    res.id = rvcls_pkg::I_SH;
                    3'd2:    res.id = rvcls_pkg::I_SW;
                    default: res.ok = 1'b0;
                endcase
            end
            rvcls_pkg::OPC_FENCE: begin
                res.fmt = rvcls_pkg::FMT_MISC;
                res.id  = rvcls_pkg::I_FENCE;
            end
            rvcls_pkg::OPC_SYSTEM: begin
                res.fmt = rvcls_pkg::FMT_MISC;
                res.id  = instr[20] ? rvcls_pkg::I_EBREAK : rvcls_pkg::I_ECALL;
            end
            default: res.ok = 1'b0;
        endcase
    end

endmodule

// File: rtl/rvcls_comp_dec.sv
// ----------------------------------------------------------------------------
// rvcls_comp_dec
// Combinational decoder for 16-bit compressed instructions.
// ----------------------------------------------------------------------------
module rvcls_comp_dec (
    input  logic [15:0]              instr,
    output rvcls_pkg::dec_res_t      res
);

    logic [1:0] quad;
    logic [2:0] f3;
    logic [4:0] rd;
    logic [4:0] rs2;

    assign quad = instr[1:0];
    assign f3   = instr[15:13];
    assign rd   = instr[11:7];
    assign rs2  = instr[6:2];

    always_comb begin
        res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_BAD, id: 7'd0};
        case (quad)
            rvcls_pkg::QUAD_0: begin
                case (f3)
                    3'd0: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CIW, id: rvcls_pkg::K_ADDI4SPN};
                    3'd2: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CL,  id: rvcls_pkg::K_LW};
                    3'd5: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CS,  id: rvcls_pkg::K_FSD};
                    3'd6: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CS,  id: rvcls_pkg::K_SW};
                    default: res.ok = 1'b0;
                endcase
            end
            rvcls_pkg::QUAD_1: begin
                case (f3)
                    3'd0: begin
                        res.fmt = rvcls_pkg::FMT_CI;
                        res.id  = (rd == 5'd0) ? rvcls_pkg::K_NOP : rvcls_pkg::K_ADDI;
                    end
                    3'd1: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CJ, id: rvcls_pkg::K_JAL};
                    3'd2: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CI, id: rvcls_pkg::K_LI};
                    3'd3: begin
                        res.fmt = rvcls_pkg::FMT_CI;
                        res.id  = (rd == 5'd2) ? rvcls_pkg::K_ADDI16SP : rvcls_pkg::K_LUI;
                    end
                    3'd4: begin
                        case (instr[11:10])
                            2'd0: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CB, id: rvcls_pkg::K_SRLI};
                            2'd1: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CB, id: rvcls_pkg::K_SRAI};
                            2'd2: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CB, id: rvcls_pkg::K_ANDI};
                            default: begin
                                // SUB, XOR, OR, AND are consecutive ids
                                res.fmt = rvcls_pkg::FMT_CA;
                                res.id  = rvcls_pkg::K_SUB + {5'd0, instr[6:5]};
                            end
                        endcase
                    end
                    3'd5: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CJ, id: rvcls_pkg::K_J};
                    3'd6: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CB, id: rvcls_pkg::K_BEQZ};
                    default: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CB, id: rvcls_pkg::K_BNEZ};
                endcase
            end
            default: begin
                case (f3)
                    3'd0: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CI, id: rvcls_pkg::K_SLLI};
                    3'd2: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CI, id: rvcls_pkg::K_LWSP};
                    3'd4: begin
                        res.fmt = rvcls_pkg::FMT_CR;
                        if (!instr[12]) begin
                            res.id = (rs2 == 5'd0) ? rvcls_pkg::K_JR : rvcls_pkg::K_MV;
                        end else if (rd == 5'd0) begin
                            res.id = rvcls_pkg::K_EBREAK;
                        end else begin
                            res.id = (rs2 == 5'd0) ? rvcls_pkg::K_JALR : rvcls_pkg::K_ADD;
                        end
                    end
                    3'd6: res = '{ok: 1'b1, fmt: rvcls_pkg::FMT_CSS, id: rvcls_pkg::K_SWSP};
                    default: res.ok = 1'b0;
                endcase
            end
        endcase
    end

endmodule

// File: rtl/rv32e_rvc_instruction_classifier_core.sv
// ----------------------------------------------------------------------------
// rv32e_rvc_instruction_classifier_core
// Classifies one RV32E or compressed instruction word per transfer.
// ----------------------------------------------------------------------------
// One instruction word goes in per input transfer and one classification
// comes out per output transfer, in order. Each word passes an input
// register, one level of opcode/funct matching and a result register, and
// a new word is taken every cycle while the
// output side keeps up (one item per cycle sustained). The pipeline stalls
// only when m_tready is low and both stages hold data. Words whose low two
// bits are 11 are decoded as 32-bit RV32E; all others use the low 16 bits
// as a compressed instruction. Unknown encodings report illegal with format
// class 16 and id 0.
// ----------------------------------------------------------------------------
module rv32e_rvc_instruction_classifier_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instr_word
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] is_compressed, [5:1] format_class,
                                   // [12:6] instr_id, [13] illegal, [15:14] zero
);

    logic        in_valid_reg;
    logic [31:0] instr_reg;
    logic        out_valid_reg;
    logic [13:0] result_reg;
    logic [13:0] result_next;
    logic        out_ready;

    rvcls_pkg::dec_res_t base_res;
    rvcls_pkg::dec_res_t comp_res;
    rvcls_pkg::dec_res_t sel_res;
    logic                is_comp;

    // Output stage can take new data when empty or being drained
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    rvcls_base_dec u_base_dec (
        .instr (instr_reg),
        .res   (base_res)
    );

    rvcls_comp_dec u_comp_dec (
        .instr (instr_reg[15:0]),
        .res   (comp_res)
    );

    // Pick the decoder by the low bits; force the illegal encoding
    always_comb begin
        is_comp = (instr_reg[1:0] != rvcls_pkg::QUAD_BASE);
        sel_res = is_comp ? comp_res : base_res;
        if (sel_res.ok) begin
            result_next = {1'b0, sel_res.id, sel_res.fmt, is_comp};
        end else begin
            result_next = {1'b1, 7'd0, rvcls_pkg::FMT_BAD, is_comp};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // advance the input stage whenever it may be refilled
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            // advance the result stage, hold it while stalled
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            instr_reg <= s_tdata;
        end
        if (in_valid_reg && out_ready) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

endmodule

// File: sim/rv32e_rvc_instruction_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// rv32e_rvc_instruction_classifier_core_tb
// Streams RV32E and compressed instruction words through the classifier and
// checks every classification against an independent decode of the same word.
// Directed words cover the field extremes and the corner encodings, then
// biased random words cover the rest, under random input gaps and output
// back-pressure.
// ----------------------------------------------------------------------------
package rvcls_tb_pkg;

    import rvcls_pkg::*;

    // funct3 values of the base opcodes
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SR  = 3'd5, F3_OR  = 3'd6, F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
    localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_BU = 3'd4, F3_HU = 3'd5;

    // funct3 values of the compressed quadrants
    localparam logic [2:0] C0_ADDI4SPN = 3'd0, C0_LW = 3'd2, C0_FSD = 3'd5, C0_SW = 3'd6;
    localparam logic [2:0] C1_ADDI = 3'd0, C1_JAL = 3'd1, C1_LI = 3'd2, C1_LUI = 3'd3;
    localparam logic [2:0] C1_ARITH = 3'd4, C1_J = 3'd5, C1_BEQZ = 3'd6, C1_BNEZ = 3'd7;
    localparam logic [2:0] C2_SLLI = 3'd0, C2_LWSP = 3'd2, C2_CR = 3'd4, C2_SWSP = 3'd6;

    // bits 11..10 of the quadrant 1 arithmetic group
    localparam logic [1:0] CB_SRLI = 2'd0, CB_SRAI = 2'd1, CB_ANDI = 2'd2;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_SP   = 5'd2;

    typedef struct packed {
        logic       comp;
        logic [4:0] fmt;
        logic [6:0] id;
        logic       bad;
    } word_class_t;

    function automatic word_class_t classify_word(logic [31:0] w);
        word_class_t r;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs2;
        logic        ok;
        r.comp = (w[1:0] != QUAD_BASE);
        r.fmt  = FMT_BAD;
        r.id   = '0;
        ok     = 1'b1;
        if (!r.comp) begin
            f3 = w[14:12];
            case (w[6:0])
                OPC_OP: begin
                    r.fmt = FMT_R;
                    case (f3)
                        F3_ADD, F3_SR: begin
                            if (w[31:25] == F7_BASE)
                                r.id = (f3 == F3_ADD) ? I_ADD : I_SRL;
                            else if (w[31:25] == F7_ALT)
                                r.id = (f3 == F3_ADD) ? I_SUB : I_SRA;
                            else
                                ok = 1'b0;
                        end
                        F3_SLL:  r.id = I_SLL;
                        F3_SLT:  r.id = I_SLT;
                        F3_SLTU: r.id = I_SLTU;
                        F3_XOR:  r.id = I_XOR;
                        F3_OR:   r.id = I_OR;
                        default: r.id = I_AND;
                    endcase
                end
                OPC_OP_IMM: begin
                    r.fmt = FMT_I;
                    case (f3)
                        F3_SR: begin
                            if (w[31:25] == F7_BASE)     r.id = I_SRLI;
                            else if (w[31:25] == F7_ALT) r.id = I_SRAI;
                            else                         ok = 1'b0;
                        end
                        F3_ADD:  r.id = I_ADDI;
                        F3_SLL:  r.id = I_SLLI;
                        F3_SLT:  r.id = I_SLTI;
                        F3_SLTU: r.id = I_SLTIU;
                        F3_XOR:  r.id = I_XORI;
                        F3_OR:   r.id = I_ORI;
                        default: r.id = I_ANDI;
                    endcase
                end
                OPC_BRANCH: begin
                    r.fmt = FMT_B;
                    case (f3)
                        F3_BEQ:  r.id = I_BEQ;
                        F3_BNE:  r.id = I_BNE;
                        F3_BLT:  r.id = I_BLT;
                        F3_BGE:  r.id = I_BGE;
                        F3_BLTU: r.id = I_BLTU;
                        F3_BGEU: r.id = I_BGEU;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_LUI: begin
                    r.fmt = FMT_U;
                    r.id  = I_LUI;
                end
                OPC_AUIPC: begin
                    r.fmt = FMT_U;
                    r.id  = I_AUIPC;
                end
                OPC_JAL: begin
                    r.fmt = FMT_J;
                    r.id  = I_JAL;
                end
                OPC_JALR: begin
                    r.fmt = FMT_I;
                    r.id  = I_JALR;
                end
                OPC_LOAD: begin
                    r.fmt = FMT_I;
                    case (f3)
                        F3_B:    r.id = I_LB;
                        F3_H:    r.id = I_LH;
                        F3_W:    r.id = I_LW;
                        F3_BU:   r.id = I_LBU;
                        F3_HU:   r.id = I_LHU;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_STORE: begin
                    r.fmt = FMT_S;
                    case (f3)
                        F3_B:    r.id = I_SB;
                        F3_H:    r.id = I_SH;
                        F3_W:    r.id = I_SW;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_FENCE: begin
                    r.fmt = FMT_MISC;
                    r.id  = I_FENCE;
                end
                OPC_SYSTEM: begin
                    r.fmt = FMT_MISC;
                    r.id  = w[20] ? I_EBREAK : I_ECALL;
                end
                default: ok = 1'b0;
            endcase
        end else begin
            f3  = w[15:13];
            rd  = w[11:7];
            rs2 = w[6:2];
            case (w[1:0])
                QUAD_0: begin
                    case (f3)
                        C0_ADDI4SPN: begin
                            r.fmt = FMT_CIW;
                            r.id  = K_ADDI4SPN;
                        end
                        C0_LW: begin
                            r.fmt = FMT_CL;
                            r.id  = K_LW;
                        end
                        C0_FSD: begin
                            r.fmt = FMT_CS;
                            r.id  = K_FSD;
                        end
                        C0_SW: begin
                            r.fmt = FMT_CS;
                            r.id  = K_SW;
                        end
                        default: ok = 1'b0;
                    endcase
                end
                QUAD_1: begin
                    case (f3)
                        C1_ADDI: begin
                            r.fmt = FMT_CI;
                            r.id  = (rd == REG_ZERO) ? K_NOP : K_ADDI;
                        end
                        C1_JAL: begin
                            r.fmt = FMT_CJ;
                            r.id  = K_JAL;
                        end
                        C1_LI: begin
                            r.fmt = FMT_CI;
                            r.id  = K_LI;
                        end
                        C1_LUI: begin
                            r.fmt = FMT_CI;
                            r.id  = (rd == REG_SP) ? K_ADDI16SP : K_LUI;
                        end
                        C1_ARITH: begin
                            case (w[11:10])
                                CB_SRLI: begin
                                    r.fmt = FMT_CB;
                                    r.id  = K_SRLI;
                                end
                                CB_SRAI: begin
                                    r.fmt = FMT_CB;
                                    r.id  = K_SRAI;
                                end
                                CB_ANDI: begin
                                    r.fmt = FMT_CB;
                                    r.id  = K_ANDI;
                                end
                                default: begin
                                    // SUB, XOR, OR, AND follow bits 6..5 in order
                                    r.fmt = FMT_CA;
                                    r.id  = K_SUB + {5'd0, w[6:5]};
                                end
                            endcase
                        end
                        C1_J: begin
                            r.fmt = FMT_CJ;
                            r.id  = K_J;
                        end
                        C1_BEQZ: begin
                            r.fmt = FMT_CB;
                            r.id  = K_BEQZ;
                        end
                        default: begin
                            r.fmt = FMT_CB;
                            r.id  = K_BNEZ;
                        end
                    endcase
                end
                default: begin
                    case (f3)
                        C2_SLLI: begin
                            r.fmt = FMT_CI;
                            r.id  = K_SLLI;
                        end
                        C2_LWSP: begin
                            r.fmt = FMT_CI;
                            r.id  = K_LWSP;
                        end
                        C2_CR: begin
                            r.fmt = FMT_CR;
                            if (!w[12])
                                r.id = (rs2 == REG_ZERO) ? K_JR : K_MV;
                            else if (rd == REG_ZERO)
                                r.id = K_EBREAK;
                            else
                                r.id = (rs2 == REG_ZERO) ? K_JALR : K_ADD;
                        end
                        C2_SWSP: begin
                            r.fmt = FMT_CSS;
                            r.id  = K_SWSP;
                        end
                        default: ok = 1'b0;
                    endcase
                end
            endcase
        end
        if (!ok) begin
            r.fmt = FMT_BAD;
            r.id  = '0;
        end
        r.bad = !ok;
        return r;
    endfunction

    class decode_tracker;
        word_class_t expected_decodes[$];
        int          mismatches = 0;

        function void note_word(logic [31:0] w);
            expected_decodes.push_back(classify_word(w));
        endfunction

        function int pending();
            return expected_decodes.size();
        endfunction

        function void compare_field(string name, logic [6:0] want, logic [6:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // m_tdata: [0] is_compressed, [5:1] format_class, [12:6] instr_id,
        // [13] illegal, [15:14] zero fill
        function void check_decode(logic [15:0] d);
            word_class_t want;
            if (expected_decodes.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected: expected none, actual %h",
                         $time, d);
                return;
            end
            want = expected_decodes.pop_front();
            compare_field("is_compressed", {6'd0, want.comp}, {6'd0, d[0]});
            compare_field("format_class", {2'd0, want.fmt}, {2'd0, d[5:1]});
            compare_field("instr_id", want.id, d[12:6]);
            compare_field("illegal", {6'd0, want.bad}, {6'd0, d[13]});
            compare_field("zero fill", 7'd0, {5'd0, d[15:14]});
        endfunction
    endclass

endpackage

module rv32e_rvc_instruction_classifier_core_tb;

    import rvcls_pkg::*;
    import rvcls_tb_pkg::*;

    localparam int N_DIRECTED  = 30;
    localparam int N_WORDS     = 1650;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] instr_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] is_compressed, [5:1] format_class,
                                  // [12:6] instr_id, [13] illegal, [15:14] zero

    logic [31:0]   directed_words [N_DIRECTED];
    decode_tracker tracker;
    rx_mode_t      rx_mode     = RX_STEADY;
    int            rx_left     = 0;
    int            stall_count = 0;

    rv32e_rvc_instruction_classifier_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Base word with a mostly known opcode; bias funct7 of OP and OP-IMM
    // toward the two legal values so the shift and add/sub splits get hit.
    function automatic logic [31:0] random_base_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 12))
            0:       w[6:0] = OPC_OP;
            1:       w[6:0] = OPC_OP_IMM;
            2:       w[6:0] = OPC_BRANCH;
            3:       w[6:0] = OPC_LUI;
            4:       w[6:0] = OPC_AUIPC;
            5:       w[6:0] = OPC_JAL;
            6:       w[6:0] = OPC_JALR;
            7:       w[6:0] = OPC_LOAD;
            8:       w[6:0] = OPC_STORE;
            9:       w[6:0] = OPC_FENCE;
            10:      w[6:0] = OPC_SYSTEM;
            default: w[1:0] = QUAD_BASE;   // any opcode, mostly unknown ones
        endcase
        if (w[6:0] == OPC_OP || w[6:0] == OPC_OP_IMM) begin
            case ($urandom_range(0, 3))
                0, 1:    w[31:25] = F7_BASE;
                2:       w[31:25] = F7_ALT;
                default: ;
            endcase
        end
        return w;
    endfunction

    // Compressed word in one of the three quadrants; bias rd and rs2 toward
    // the register numbers that change the decode.
    function automatic logic [31:0] random_comp_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 2))
            0:       w[1:0] = QUAD_0;
            1:       w[1:0] = QUAD_1;
            default: w[1:0] = QUAD_2;
        endcase
        case ($urandom_range(0, 7))
            0:       w[11:7] = REG_ZERO;
            1:       w[11:7] = REG_SP;
            2:       w[6:2]  = REG_ZERO;
            3: begin
                w[11:7] = REG_ZERO;
                w[6:2]  = REG_ZERO;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return random_base_word();
            4, 5, 6, 7: return random_comp_word();
            default:    return $urandom();
        endcase
    endfunction

    // Present one word and hold it until the block takes the transfer.
    task automatic send_word(input logic [31:0] w);
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid for a gap between bursts.
    task automatic idle_cycles(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Receiver back-pressure: switch at random between steady, coin-flip,
    // sparse and periodic stall patterns.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 80);
        end
        case (rx_mode)
            RX_STEADY:   m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_tready <= ((rx_left % 8) >= 3);
            default:     m_tready <= 1'b1;
        endcase
        rx_left--;
    end

    // Sample both channels at the edge: note each accepted word and check
    // each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_word(s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_decode(m_tdata);
        end
    end

    // End the run if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int sent;
        int burst;
        tracker = new();
        directed_words = '{
            32'h0000_0000,  // all zero: C.ADDI4SPN
            32'hFFFF_FFFF,  // all ones: unknown base opcode
            32'h0031_00B3,  // ADD
            32'h4031_00B3,  // SUB
            32'h0231_00B3,  // ADD/SUB with a bad funct7
            32'h4031_50B3,  // SRA
            32'h4031_5093,  // SRAI
            32'hFE31_5093,  // SRLI/SRAI with a bad funct7
            32'hFE31_1093,  // SLLI ignores funct7
            32'hFFFF_F0E7,  // JALR ignores funct3
            32'h0FF0_000F,  // FENCE
            32'h0000_0073,  // ECALL
            32'h0010_0073,  // EBREAK
            32'h0000_2063,  // branch with an unassigned funct3
            32'h0000_3003,  // load with an unassigned funct3
            32'h0000_7023,  // store with an unassigned funct3
            32'hFFFF_0001,  // C.NOP, upper half ignored
            32'h0000_0085,  // C.ADDI
            32'h0000_6101,  // C.ADDI16SP
            32'h0000_6085,  // C.LUI
            32'h0000_9C41,  // C.OR with bit 12 set
            32'h0000_8405,  // C.SRAI
            32'h0000_8082,  // C.JR
            32'h0000_8086,  // C.MV
            32'h0000_9002,  // C.EBREAK
            32'h0000_9082,  // C.JALR
            32'h0000_9086,  // C.ADD
            32'h0000_A000,  // C.FSD
            32'h0000_2000,  // quadrant 0 unassigned
            32'h0000_E002   // quadrant 2 unassigned
        };

        // Hold reset at the start, then release it.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Send in bursts; most bursts end in a short gap, some run back to back.
        sent = 0;
        while (sent < N_WORDS) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                if (sent < N_WORDS) begin
                    send_word(sent < N_DIRECTED ? directed_words[sent] : random_word());
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
        s_tvalid <= 1'b0;

        // Drain, then give the two-stage pipe time to show any extra result.
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rvcls_pkg.sv
rtl/rvcls_base_dec.sv
rtl/rvcls_comp_dec.sv
rtl/rv32e_rvc_instruction_classifier_core.sv
sim/rv32e_rvc_instruction_classifier_core_tb.sv
